/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is low.
`define WM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wmerc checker: property failed");

// Concurrent assertion that is checked in every cycle, reset included.
`define WM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("wmerc checker: property failed");

`endif

/* sv/wmerc_pkg.sv */
package wmerc_pkg;

  // Map geometry.
  localparam int MAX_ZOOM       = 22;
  localparam int TILE_SIDE_LOG2 = 8;
  localparam int PIX_W          = 30;
  localparam int PT_W           = PIX_W + 1;
  localparam int SH_W           = 5;
  localparam int LAT_W          = 32;
  localparam int ZOOM_W         = 5;

  // Input clipping limits in units of 2^-22 degree.
  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 32'sd356730290;
  localparam logic signed [LAT_W-1:0] LNG_LIMIT = 32'sd754974720;
  localparam int ALAT_W = 29;
  localparam int XU_W   = 31;

  // Horizontal path: floor((xu * 2^sh + 45 * 2^24) / (45 * 2^25)).
  localparam int XS_W  = 62;
  localparam int XR_SH = 25;
  localparam int U_W   = 36;
  localparam int UL    = 18;
  localparam int XR_K  = 42;
  localparam int XR_W  = 37;
  localparam int PP_W  = UL + XR_W;
  localparam int XP_W  = PP_W + UL;
  localparam logic [XS_W-1:0] X_BIAS = XS_W'(64'd45 << 24);
  localparam longint unsigned X_RECIP_L = ((64'd1 << XR_K) + 64'd44) / 64'd45;
  localparam logic [XR_W-1:0] X_RECIP = XR_W'(X_RECIP_L);

  // CORDIC datapaths: FC fractional bits, angle in 2^-(22+ZF) degree.
  localparam int FC = 48;
  localparam int CW = FC + 3;
  localparam int HW = CW + 1;
  localparam int ZF = 20;
  localparam int NC = 48;
  localparam int NH = 51;
  localparam int YQ_W = CW - 1;
  localparam int RS_W = 6;

  // Edges from the accepting edge to the edge that raises the strobe.
  localparam int PIPE_LAT = NC + NH + 6;

  localparam real PI_R        = 3.14159265358979323846;
  localparam real INV_PI      = 1.0 / PI_R;
  localparam real DEG_PER_RAD = 180.0 / PI_R;

  typedef struct packed {
    logic signed [LAT_W-1:0] latitude;
    logic signed [LAT_W-1:0] longitude;
    logic [ZOOM_W-1:0]       zoom_level;
  } wmerc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } wmerc_out_t;

  // Per-item data that rides along the pipeline.
  typedef struct packed {
    logic             south;
    logic [SH_W-1:0]  sh;
    logic [2:0]       nrm;
    logic [PIX_W-1:0] px;
  } side_t;

  // Map side exponent for a zoom level, zoom clamped to MAX_ZOOM.
  function automatic logic [SH_W-1:0] zoom_sh(input logic [ZOOM_W-1:0] zoom);
    logic [ZOOM_W-1:0] zc;
    zc = (zoom > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom;
    return SH_W'(TILE_SIDE_LOG2) + SH_W'(zc);
  endfunction

  // Largest pixel index for a map side of 2^sh.
  function automatic logic [PT_W-1:0] pix_top(input logic [SH_W-1:0] sh);
    return (PT_W'(1) << sh) - PT_W'(1);
  endfunction

  // Circular CORDIC angle for step i, in 2^-(22+ZF) degree.
  function automatic logic signed [CW-1:0] circ_atan(input int i);
    real r;
    r = $atan(2.0 ** (-i)) * DEG_PER_RAD * (2.0 ** (ZF + 22));
    return CW'(longint'(r));
  endfunction

  // Start value of x: the inverse of the circular CORDIC gain.
  function automatic logic signed [CW-1:0] circ_x0();
    real g;
    int  i;
    g = 1.0;
    for (i = 0; i < NC; i++) begin
      g = g * $cos($atan(2.0 ** (-i)));
    end
    return CW'(longint'((2.0 ** FC) * g));
  endfunction

  // Shift of hyperbolic step k: 1, 2, 3, 4, 4, 5, ... with 4, 13 and 40 repeated.
  function automatic int hyp_shift(input int k);
    int   i;
    int   cnt;
    logic rep;
    i   = 1;
    cnt = 0;
    rep = 1'b0;
    while (cnt < k) begin
      if ((i == 4 || i == 13 || i == 40) && !rep) begin
        rep = 1'b1;
      end else begin
        rep = 1'b0;
        i   = i + 1;
      end
      cnt = cnt + 1;
    end
    return i;
  endfunction

  // Hyperbolic step angle, scaled by 1/pi into FC fractional bits.
  function automatic logic signed [CW-1:0] hyp_atanh(input int k);
    real r;
    r = $atanh(2.0 ** (-hyp_shift(k))) * INV_PI * (2.0 ** FC);
    return CW'(longint'(r));
  endfunction

  // ln(2) / (2*pi) in FC fractional bits.
  function automatic logic signed [CW-1:0] ln2_2pi();
    return CW'(longint'($ln(2.0) * 0.5 * INV_PI * (2.0 ** FC)));
  endfunction

endpackage

/* sv/web_mercator_latlng_to_pixel_unit.sv */
// Channel   Ports                         Direction  Word
// input     start, busy, in_word          in         latitude, longitude, zoom_level
// result    out_strobe, out_word          out        pixel_x, pixel_y
//
// One word is taken in every cycle; busy stays low.
// The result strobe rises at the end of the pipeline: one input
// stage, 48 circular CORDIC stages for sin/cos, 51 hyperbolic CORDIC stages
// for the log ratio, and six stages of setup, normalization and rounding.
// Reset clears only the valid flags; words in flight are dropped.
// The receiver cannot stall, so the pipeline advances in every cycle.
module web_mercator_latlng_to_pixel_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  wmerc_pkg::wmerc_in_t   in_word,
  output logic                   out_strobe,
  output wmerc_pkg::wmerc_out_t  out_word
);
  import wmerc_pkg::*;

  localparam logic signed [CW-1:0] CIRC_X0 = circ_x0();
  localparam logic signed [CW-1:0] LN2_C   = ln2_2pi();
  localparam logic signed [CW-1:0] ONE_C   = CW'(64'd1 << FC);
  localparam logic signed [CW-1:0] HALF_C  = CW'(64'd1 << (FC - 1));
  localparam logic signed [CW-1:0] QTR_C   = CW'(64'd1 << (FC - 2));
  localparam logic signed [CW-1:0] EIGHTH_C = CW'(64'd1 << (FC - 3));

  // Input stage: clip both angles and clamp the zoom.
  logic signed [LAT_W-1:0] lat_c;
  logic signed [LAT_W-1:0] lng_c;
  logic [ALAT_W-1:0]       alat_nxt;
  logic [XU_W-1:0]         xu_nxt;
  side_t                   s1_sd_nxt;

  logic                    s1_vld_r;
  logic [ALAT_W-1:0]       s1_alat_r;
  logic [XU_W-1:0]         s1_xu_r;
  side_t                   s1_sd_r;

  always_comb begin
    lat_c = in_word.latitude;
    if (lat_c > LAT_LIMIT) lat_c = LAT_LIMIT;
    if (lat_c < -LAT_LIMIT) lat_c = -LAT_LIMIT;
    lng_c = in_word.longitude;
    if (lng_c > LNG_LIMIT) lng_c = LNG_LIMIT;
    if (lng_c < -LNG_LIMIT) lng_c = -LNG_LIMIT;
    alat_nxt = lat_c[LAT_W-1] ? ALAT_W'(-lat_c) : ALAT_W'(lat_c);
    xu_nxt   = XU_W'(lng_c + LNG_LIMIT);
    s1_sd_nxt       = '0;
    s1_sd_nxt.south = lat_c[LAT_W-1];
    s1_sd_nxt.sh    = zoom_sh(in_word.zoom_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_alat_r <= alat_nxt;
    s1_xu_r   <= xu_nxt;
    s1_sd_r   <= s1_sd_nxt;
  end

  // Circular CORDIC state; index 0 is the setup stage.
  logic signed [CW-1:0] cx_r [NC+1];
  logic signed [CW-1:0] cy_r [NC+1];
  logic signed [CW-1:0] cz_r [NC+1];
  side_t                csd_r [NC+1];
  logic                 cv_r [NC+1];

  // Horizontal path registers.
  logic [XS_W-1:0] xs_c;
  logic [U_W-1:0]  u_r;
  logic [PP_W-1:0] pp_lo_r;
  logic [PP_W-1:0] pp_hi_r;
  logic [XP_W-1:0] xsum_c;
  logic [PT_W-1:0] px_w;
  logic [PT_W-1:0] top_x;
  logic [PIX_W-1:0] px_calc;

  assign xs_c = (XS_W'(s1_xu_r) << s1_sd_r.sh) + X_BIAS;

  // Setup stage: rotation starts from (1/K, 0) with the angle in z.
  always_ff @(posedge clk) begin
    cx_r[0]  <= CIRC_X0;
    cy_r[0]  <= '0;
    cz_r[0]  <= $signed({{(CW - ALAT_W - ZF){1'b0}}, s1_alat_r, {ZF{1'b0}}});
    csd_r[0] <= s1_sd_r;
    u_r      <= xs_c[XR_SH +: U_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= s1_vld_r;
    end
  end

  // Divide by 45 through a reciprocal split into two partial products.
  always_ff @(posedge clk) begin
    pp_lo_r <= u_r[UL-1:0] * X_RECIP;
    pp_hi_r <= u_r[U_W-1:UL] * X_RECIP;
  end

  always_comb begin
    xsum_c  = XP_W'(pp_lo_r) + {pp_hi_r, {UL{1'b0}}};
    px_w    = xsum_c[XR_K +: PT_W];
    top_x   = pix_top(csd_r[1].sh);
    px_calc = (px_w > top_x) ? PIX_W'(top_x) : PIX_W'(px_w);
  end

  // Circular rotation stages.
  for (genvar g = 0; g < NC; g++) begin : g_circ
    localparam logic signed [CW-1:0] ATN = circ_atan(g);

    always_ff @(posedge clk) begin
      if (cz_r[g][CW-1]) begin
        cx_r[g+1] <= cx_r[g] + (cy_r[g] >>> g);
        cy_r[g+1] <= cy_r[g] - (cx_r[g] >>> g);
        cz_r[g+1] <= cz_r[g] + ATN;
      end else begin
        cx_r[g+1] <= cx_r[g] - (cy_r[g] >>> g);
        cy_r[g+1] <= cy_r[g] + (cx_r[g] >>> g);
        cz_r[g+1] <= cz_r[g] - ATN;
      end
      if (g == 1) begin
        csd_r[g+1] <= {csd_r[g].south, csd_r[g].sh, csd_r[g].nrm, px_calc};
      end else begin
        csd_r[g+1] <= csd_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[g+1] <= 1'b0;
      end else begin
        cv_r[g+1] <= cv_r[g];
      end
    end
  end

  // Normalize cos into [1, 2] and form 1 + sin.
  logic [2:0]           nrm_c;
  logic signed [CW-1:0] n1_a_r;
  logic signed [CW-1:0] n1_b_r;
  side_t                n1_sd_r;
  logic                 n1_vld_r;

  always_comb begin
    if (cx_r[NC] >= HALF_C) begin
      nrm_c = 3'd1;
    end else if (cx_r[NC] >= QTR_C) begin
      nrm_c = 3'd2;
    end else if (cx_r[NC] >= EIGHTH_C) begin
      nrm_c = 3'd3;
    end else begin
      nrm_c = 3'd4;
    end
  end

  always_ff @(posedge clk) begin
    n1_a_r  <= ONE_C + cy_r[NC];
    n1_b_r  <= cx_r[NC] <<< nrm_c;
    n1_sd_r <= {csd_r[NC].south, csd_r[NC].sh, nrm_c, csd_r[NC].px};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r <= 1'b0;
    end else begin
      n1_vld_r <= cv_r[NC];
    end
  end

  // Hyperbolic vectoring: z ends at atanh((a-b)/(a+b)) / pi.
  logic signed [HW-1:0] hx_r [NH+1];
  logic signed [HW-1:0] hy_r [NH+1];
  logic signed [CW-1:0] hz_r [NH+1];
  side_t                hsd_r [NH+1];
  logic                 hv_r [NH+1];

  always_ff @(posedge clk) begin
    hx_r[0]  <= {n1_a_r[CW-1], n1_a_r} + {n1_b_r[CW-1], n1_b_r};
    hy_r[0]  <= {n1_a_r[CW-1], n1_a_r} - {n1_b_r[CW-1], n1_b_r};
    hz_r[0]  <= '0;
    hsd_r[0] <= n1_sd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r[0] <= 1'b0;
    end else begin
      hv_r[0] <= n1_vld_r;
    end
  end

  for (genvar k = 0; k < NH; k++) begin : g_hyp
    localparam int                   HS = hyp_shift(k);
    localparam logic signed [CW-1:0] HT = hyp_atanh(k);

    always_ff @(posedge clk) begin
      if (!hy_r[k][HW-1]) begin
        hx_r[k+1] <= hx_r[k] - (hy_r[k] >>> HS);
        hy_r[k+1] <= hy_r[k] - (hx_r[k] >>> HS);
        hz_r[k+1] <= hz_r[k] + HT;
      end else begin
        hx_r[k+1] <= hx_r[k] + (hy_r[k] >>> HS);
        hy_r[k+1] <= hy_r[k] + (hx_r[k] >>> HS);
        hz_r[k+1] <= hz_r[k] - HT;
      end
      hsd_r[k+1] <= hsd_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv_r[k+1] <= 1'b0;
      end else begin
        hv_r[k+1] <= hv_r[k];
      end
    end
  end

  // Add back the normalization: atanh(sin) / (2*pi).
  logic signed [CW-1:0] nl_c;
  logic signed [CW-1:0] f_r;
  side_t                f_sd_r;
  logic                 f_vld_r;

  // The shift count is small, so its multiple of ln(2) comes from shifts and one add.
  always_comb begin
    case (hsd_r[NH].nrm)
      3'd1:    nl_c = LN2_C;
      3'd2:    nl_c = LN2_C <<< 1;
      3'd3:    nl_c = LN2_C + (LN2_C <<< 1);
      3'd4:    nl_c = LN2_C <<< 2;
      default: nl_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    f_r    <= hz_r[NH] + nl_c;
    f_sd_r <= hsd_r[NH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= hv_r[NH];
    end
  end

  // Fold around the equator and clamp at the top edge.
  logic signed [CW-1:0] ys_c;
  logic [YQ_W-1:0]      yq_r;
  side_t                yq_sd_r;
  logic                 yq_vld_r;

  assign ys_c = f_sd_r.south ? (HALF_C + f_r) : (HALF_C - f_r);

  always_ff @(posedge clk) begin
    yq_r    <= ys_c[CW-1] ? '0 : ys_c[YQ_W-1:0];
    yq_sd_r <= f_sd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yq_vld_r <= 1'b0;
    end else begin
      yq_vld_r <= f_vld_r;
    end
  end

  // Scale by the map side, round half up and clamp.
  logic [RS_W-1:0]  rs_c;
  logic [CW-1:0]    ysum_c;
  logic [CW-1:0]    pyw_c;
  logic [PT_W-1:0]  top_y;
  logic [PIX_W-1:0] py_c;
  logic             out_strobe_r;
  wmerc_out_t       out_word_r;

  always_comb begin
    rs_c   = RS_W'(FC - 1) - RS_W'(yq_sd_r.sh);
    ysum_c = {1'b0, yq_r} + (CW'(1) << rs_c);
    pyw_c  = ysum_c >> (rs_c + RS_W'(1));
    top_y  = pix_top(yq_sd_r.sh);
    py_c   = (pyw_c[PT_W-1:0] > top_y) ? PIX_W'(top_y) : pyw_c[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    out_word_r.pixel_x <= yq_sd_r.px;
    out_word_r.pixel_y <= py_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= yq_vld_r;
    end
  end

  assign busy       = 1'b0;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

/* sv/wmerc_checker.sv */
`include "assert_macros.svh"

module wmerc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input wmerc_pkg::wmerc_in_t  in_word,
  input logic                  out_strobe,
  input wmerc_pkg::wmerc_out_t out_word
);
  import wmerc_pkg::*;

  localparam int CHK_LAT = PIPE_LAT + 1;
  localparam int SC_W    = $clog2(CHK_LAT + 1);

  // Count clock edges since reset, saturating at the pipeline depth.
  logic [SC_W-1:0] since_r;
  logic [SC_W-1:0] since_nxt;

  always_comb begin
    since_nxt = (since_r == SC_W'(CHK_LAT)) ? since_r : since_r + SC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= '0;
    end else begin
      since_r <= since_nxt;
    end
  end

  // Every accepted word comes out exactly once, a fixed time later.
  `WM_ASSERT_ALWAYS(a_strobe_lat, (since_r == SC_W'(CHK_LAT)) |-> (out_strobe == $past(start && !busy, CHK_LAT)))

  // Both pixel coordinates stay inside the map of the word's zoom level.
  `WM_ASSERT(a_px_range, (out_strobe && since_r == SC_W'(CHK_LAT)) |-> ({1'b0, out_word.pixel_x} <= pix_top(zoom_sh($past(in_word.zoom_level, CHK_LAT)))))
  `WM_ASSERT(a_py_range, (out_strobe && since_r == SC_W'(CHK_LAT)) |-> ({1'b0, out_word.pixel_y} <= pix_top(zoom_sh($past(in_word.zoom_level, CHK_LAT)))))

endmodule

bind web_mercator_latlng_to_pixel_unit wmerc_checker u_wmerc_checker (.*);

/* test/web_mercator_latlng_to_pixel_unit_checker.sv */
// Watches both channels, predicts every pixel and compares it with the block's word.
module web_mercator_latlng_to_pixel_unit_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  wmerc_pkg::wmerc_in_t  in_word,
  input  logic                  out_strobe,
  input  wmerc_pkg::wmerc_out_t out_word,
  output int                    fail_count,
  output int                    pixels_pending
);
  import wmerc_pkg::*;

  typedef longint unsigned u64_t;

  localparam u64_t PI_Q60   = 64'h3243F6A8885A308D;
  localparam u64_t LN2_Q64  = 64'hB17217F7D1CF79AB;
  localparam u64_t ONE_Q62  = 64'h4000000000000000;
  localparam u64_t HALF_Q62 = 64'h2000000000000000;

  wmerc_out_t pixel_fifo[$];

  assign pixels_pending = pixel_fifo.size();

  // Full product shifted right, kept to 64 bits.
  function automatic u64_t prod_shr(input u64_t a, input u64_t b, input int sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return u64_t'(p >> sh);
  endfunction

  // Bit-serial fraction (a << bits) / b.
  function automatic u64_t fraction(input u64_t a, input u64_t b, input int bits);
    u64_t q;
    q = 0;
    if (b == 0) return 0;
    if (a >= b) a = b - 1;
    for (int i = 0; i < bits; i++) begin
      a = a << 1;
      q = q << 1;
      if (a >= b) begin
        a = a - b;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Sine of a Q61 angle by Taylor series.
  function automatic u64_t sine_q61(input u64_t phi);
    u64_t p2, term, sum;
    p2   = prod_shr(phi, phi, 61);
    term = phi;
    sum  = phi;
    for (u64_t k = 1; k <= 30 && term != 0; k++) begin
      term = prod_shr(term, p2, 61) / ((2 * k) * (2 * k + 1));
      if (k[0]) sum = (term > sum) ? 0 : sum - term;
      else      sum = sum + term;
    end
    return sum;
  endfunction

  // Natural log of a Q62 mantissa in [1,2).
  function automatic u64_t log_mant_q62(input u64_t m);
    u64_t u, u2, term, sum;
    u    = fraction((m - ONE_Q62) >> 1, (m + ONE_Q62) >> 1, 62);
    u2   = prod_shr(u, u, 62);
    term = u;
    sum  = 0;
    for (u64_t k = 0; k < 32 && term != 0; k++) begin
      sum  = sum + term / (2 * k + 1);
      term = prod_shr(term, u2, 62);
    end
    return sum << 1;
  endfunction

  // Projects one coordinate word onto the map.
  function automatic wmerc_out_t project(input wmerc_in_t w);
    longint     lat, lng;
    u64_t       z, sh, top, xu, px, py, alat, phi, s62, ln_a, ln_b, v, n, mag, g60, f, yq;
    logic       south;
    wmerc_out_t r;
    lat = longint'(w.latitude);
    lng = longint'(w.longitude);
    z   = u64_t'(w.zoom_level);
    if (lat > longint'(LAT_LIMIT))  lat = longint'(LAT_LIMIT);
    if (lat < -longint'(LAT_LIMIT)) lat = -longint'(LAT_LIMIT);
    if (lng > longint'(LNG_LIMIT))  lng = longint'(LNG_LIMIT);
    if (lng < -longint'(LNG_LIMIT)) lng = -longint'(LNG_LIMIT);
    if (z > MAX_ZOOM) z = MAX_ZOOM;
    sh  = TILE_SIDE_LOG2 + z;
    top = (u64_t'(1) << sh) - 1;

    // Horizontal pixel, exact with half-up rounding.
    xu = u64_t'(lng + longint'(LNG_LIMIT));
    if (sh >= 25) px = ((xu << (sh - 24)) + 45) / 90;
    else          px = ((xu << sh) + (u64_t'(45) << 24)) / (u64_t'(45) << 25);
    if (px > top) px = top;

    // Vertical pixel from atanh of the sine of the absolute latitude.
    south = lat < 0;
    alat  = u64_t'(south ? -lat : lat);
    phi   = prod_shr(alat, PI_Q60 / 45, 23);
    s62   = sine_q61(phi) << 1;
    if (s62 >= ONE_Q62) s62 = ONE_Q62 - 1;
    ln_a = log_mant_q62(ONE_Q62 + s62);
    v    = ONE_Q62 - s62;
    n    = 0;
    while (n < 63 && (v & ONE_Q62) == 0) begin
      v = v << 1;
      n++;
    end
    ln_b = log_mant_q62(v);
    mag  = n * ((LN2_Q64 >> 2) >> 1) - (ln_b >> 1);
    g60  = (((ln_a >> 1) + mag) >> 1) >> 1;
    f    = fraction(g60, PI_Q60 << 1, 62);
    if (south) yq = HALF_Q62 + f;
    else       yq = (f > HALF_Q62) ? 0 : HALF_Q62 - f;
    py = (yq + (u64_t'(1) << (61 - sh))) >> (62 - sh);
    if (py > top) py = top;

    r.pixel_x = PIX_W'(px);
    r.pixel_y = PIX_W'(py);
    return r;
  endfunction

  // The block may be one pixel off a precise evaluation.
  function automatic logic near(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d >= -1 && d <= 1;
  endfunction

  initial fail_count = 0;

  // Record accepted words and compare each result word with the oldest prediction.
  always @(posedge clk) begin
    wmerc_out_t want;
    if (rst_n && out_strobe) begin
      if (pixel_fifo.size() == 0) begin
        $display("%0t: unexpected result word x=%0d y=%0d", $time,
                 out_word.pixel_x, out_word.pixel_y);
        fail_count++;
      end else begin
        want = pixel_fifo.pop_front();
        if (!near(want.pixel_x, out_word.pixel_x)) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time,
                   want.pixel_x, out_word.pixel_x);
          fail_count++;
        end
        if (!near(want.pixel_y, out_word.pixel_y)) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time,
                   want.pixel_y, out_word.pixel_y);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      pixel_fifo.push_back(project(in_word));
    end
  end

endmodule

/* test/web_mercator_latlng_to_pixel_unit_tb.sv */
module web_mercator_latlng_to_pixel_unit_tb;
  import wmerc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  wmerc_in_t  in_word;
  logic       out_strobe;
  wmerc_out_t out_word;
  int         fail_count;
  int         pixels_pending;
  int         idle_pct;

  web_mercator_latlng_to_pixel_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word)
  );

  web_mercator_latlng_to_pixel_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .fail_count(fail_count), .pixels_pending(pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Offers one coordinate word, with random idle cycles ahead of it.
  task automatic send_point(input logic signed [31:0] lat, input logic signed [31:0] lng,
                            input logic [4:0] zoom);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_word.latitude   <= lat;
    in_word.longitude  <= lng;
    in_word.zoom_level <= zoom;
    do @(posedge clk); while (busy);
  endtask

  // Random coordinate: mostly on the map, sometimes anywhere in the field.
  function automatic logic signed [31:0] rand_coord(input logic signed [31:0] lim);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return $signed($urandom_range(2 * lim)) - lim;
    if (pick < 80) return $urandom_range(1) ? lim : -lim;
    return $signed($urandom);
  endfunction

  initial begin
    logic [4:0] zoom;
    int         waited;
    start    = 1'b0;
    in_word  = '0;
    rst_n    = 1'b0;
    idle_pct = 14;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, clipping edges, equator, poles and zoom clamp.
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 5'd0);
    send_point(32'sh80000000, 32'sh80000000, 5'd0);
    send_point(LAT_LIMIT, LNG_LIMIT, 5'd22);
    send_point(-LAT_LIMIT, -LNG_LIMIT, 5'd22);
    send_point(LAT_LIMIT - 1, LNG_LIMIT - 1, 5'd22);
    send_point(-LAT_LIMIT + 1, -LNG_LIMIT + 1, 5'd22);
    send_point(LAT_LIMIT + 1, LNG_LIMIT + 1, 5'd10);
    send_point(32'sd0, 32'sd0, 5'd0);
    send_point(32'sd0, 32'sd0, 5'd22);
    send_point(32'sd1, -32'sd1, 5'd22);
    send_point(-32'sd1, 32'sd1, 5'd22);
    send_point(32'sd0, 32'sd0, 5'd23);
    send_point(32'sd0, 32'sd0, 5'd31);
    send_point(32'sh7FFFFFFF, 32'sh80000000, 5'd31);
    send_point(32'sh80000000, 32'sh7FFFFFFF, 5'd16);
    send_point(32'sd209715200, 32'sd377487360, 5'd12);
    send_point(-32'sd209715200, -32'sd377487360, 5'd5);
    send_point(32'sd356000000, 32'sd0, 5'd22);
    send_point(-32'sd356000000, 32'sd0, 5'd22);
    send_point(32'sh55555555, 32'shAAAAAAAA, 5'b10101);
    send_point(32'shAAAAAAAA, 32'sh55555555, 5'b01010);

    // Random words; one stretch without idling and one pause for a drained pipeline.
    for (int i = 0; i < 950; i++) begin
      idle_pct = (i >= 300 && i < 500) ? 0 : 14;
      if (i == 650) begin
        start  <= 1'b0;
        waited = 0;
        while (pixels_pending != 0) begin
          @(posedge clk);
        end
      end
      zoom = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(22));
      send_point(rand_coord(LAT_LIMIT), rand_coord(LNG_LIMIT), zoom);
    end
    start <= 1'b0;

    // Drain, then a few quiet cycles to catch stray words.
    waited = 0;
    while (pixels_pending != 0 && waited < 20 * PIPE_LAT) begin
      @(posedge clk);
      waited++;
    end
    if (pixels_pending != 0) begin
      $display("FAIL");
      $finish;
    end else begin
      repeat (PIPE_LAT + 20) @(posedge clk);
      if (fail_count == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
      $finish;
    end
  end

endmodule
